@@ hdl/cfb_pkg.sv @@
`default_nettype none

package cfb_pkg;

   localparam int unsigned BYTE_W = 8;
   localparam int unsigned CRC_W = 16;
   localparam int unsigned PAYLOAD_W = 32;
   localparam int unsigned COUNT_W = 3;
   // command byte plus up to four payload bytes, left aligned
   localparam int unsigned SHIFT_W = BYTE_W + PAYLOAD_W;

   localparam logic [CRC_W-1:0] CRC_POLY = 16'h1021;
   localparam logic [CRC_W-1:0] CRC_INIT = 16'h0000;
   localparam logic [COUNT_W-1:0] MAX_PAYLOAD = 3'd4;
   localparam logic [BYTE_W-1:0] ADDR_RESET = 8'h80;

   typedef struct packed {
      logic [BYTE_W-1:0] command;
      logic [COUNT_W-1:0] n_bytes;
      logic [PAYLOAD_W-1:0] payload;
   } item_type;

   // one byte through the msb-first crc, eight bit steps
   function automatic logic [CRC_W-1:0] crc_add_byte(input logic [CRC_W-1:0] crc,
                                                     input logic [BYTE_W-1:0] data);
      logic [CRC_W-1:0] c;
      c = crc ^ {data, 8'h00};
      for (int i = 0; i < BYTE_W; i++) begin
         if (c[CRC_W-1]) begin
            c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[CRC_W-2:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

`default_nettype wire

@@ hdl/cfb_ifs.sv @@
`default_nettype none

interface cfb_req_if;
   logic valid;
   logic ready;
   logic [7:0] command;
   logic [2:0] payload_bytes;
   logic [31:0] payload;

   modport source (output valid, command, payload_bytes, payload, input ready);
   modport sink (input valid, command, payload_bytes, payload, output ready);
endinterface

interface cfb_rsp_if;
   logic valid;
   logic ready;
   logic [7:0] frame_byte;
   logic last;

   modport source (output valid, frame_byte, last, input ready);
   modport sink (input valid, frame_byte, last, output ready);
endinterface

`default_nettype wire

@@ hdl/command_frame_builder_crc16.sv @@
// channel   dir  beat contents                         notes
// req_ch    in   command, payload_bytes, payload       one beat per frame
// rsp_ch    out  frame_byte, last                      4 + n beats, last on crc low byte
// csr_*     in   wr_en, wr_data (device address)       write only, reset 0x80
//
// a frame with n payload bytes is 4 + n bytes, one byte per cycle out of the
// serializer while rsp_ready is high; the output register sets that pace. the
// address byte is loaded into the output register as the serializer takes the item
// from the input register; frames follow back to back while a request waits there.
// rsp_ready low holds the output register and serializer; req_ready is low while the
// input register is full and not taken. reset is synchronous, clears all control state.
`default_nettype none

module command_frame_builder_crc16 (
   input wire logic clock,
   input wire logic reset,
   cfb_req_if.sink req_ch,
   cfb_rsp_if.source rsp_ch,
   input wire logic csr_wr_en,
   input wire logic [7:0] csr_wr_data
);

   logic [cfb_pkg::BYTE_W-1:0] addr_ff;
   logic [cfb_pkg::BYTE_W-1:0] addr_in;
   logic pend_valid;
   cfb_pkg::item_type pend_item;
   logic take;

   assign addr_in = csr_wr_en ? csr_wr_data : addr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         addr_ff <= cfb_pkg::ADDR_RESET;
      end else begin
         addr_ff <= addr_in;
      end
   end

   cfb_item_reg u_item_reg (
      .clock(clock),
      .reset(reset),
      .req(req_ch),
      .take(take),
      .pend_valid(pend_valid),
      .pend_item(pend_item)
   );

   cfb_serializer u_serializer (
      .clock(clock),
      .reset(reset),
      .pend_valid(pend_valid),
      .pend_item(pend_item),
      .dev_addr(addr_ff),
      .take(take),
      .rsp(rsp_ch)
   );

endmodule

`default_nettype wire

@@ hdl/cfb_item_reg.sv @@
`default_nettype none

module cfb_item_reg (
   input wire logic clock,
   input wire logic reset,
   cfb_req_if.sink req,
   input wire logic take,
   output logic pend_valid,
   output cfb_pkg::item_type pend_item
);

   logic valid_ff;
   logic valid_in;
   cfb_pkg::item_type item_ff;
   cfb_pkg::item_type item_in;
   logic fire;

   assign req.ready = !valid_ff || take;
   assign fire = req.valid && req.ready;

   always_comb begin
      valid_in = valid_ff;
      item_in = item_ff;
      if (take) begin
         valid_in = 1'b0;
      end
      if (fire) begin
         valid_in = 1'b1;
         item_in.command = req.command;
         item_in.payload = req.payload;
         // lengths above four saturate
         item_in.n_bytes = (req.payload_bytes > cfb_pkg::MAX_PAYLOAD) ?
                           cfb_pkg::MAX_PAYLOAD : req.payload_bytes;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   assign pend_valid = valid_ff;
   assign pend_item = item_ff;

endmodule

`default_nettype wire

@@ hdl/cfb_serializer.sv @@
`default_nettype none

module cfb_serializer (
   input wire logic clock,
   input wire logic reset,
   input wire logic pend_valid,
   input wire cfb_pkg::item_type pend_item,
   input wire logic [cfb_pkg::BYTE_W-1:0] dev_addr,
   output logic take,
   cfb_rsp_if.source rsp
);

   logic busy_ff, busy_in;
   logic crc_lo_ff, crc_lo_in;
   logic [cfb_pkg::COUNT_W-1:0] left_ff, left_in;
   logic [cfb_pkg::SHIFT_W-1:0] shift_ff, shift_in;
   logic [cfb_pkg::CRC_W-1:0] crc_ff, crc_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [cfb_pkg::BYTE_W-1:0] rsp_byte_ff, rsp_byte_in;
   logic rsp_last_ff, rsp_last_in;

   logic out_adv;
   logic [cfb_pkg::CRC_W-1:0] crc_base;
   logic [cfb_pkg::BYTE_W-1:0] byte_sel;
   logic [cfb_pkg::CRC_W-1:0] crc_step;
   logic [cfb_pkg::SHIFT_W-1:0] load_shift;

   assign out_adv = !rsp_valid_ff || rsp.ready;
   assign take = out_adv && !busy_ff && pend_valid;

   // payload bytes to send, most significant first, left aligned behind the command
   always_comb begin
      case (pend_item.n_bytes)
         3'd0: load_shift = {pend_item.command, 32'h0000_0000};
         3'd1: load_shift = {pend_item.command, pend_item.payload[7:0], 24'h00_0000};
         3'd2: load_shift = {pend_item.command, pend_item.payload[15:0], 16'h0000};
         3'd3: load_shift = {pend_item.command, pend_item.payload[23:0], 8'h00};
         default: load_shift = {pend_item.command, pend_item.payload};
      endcase
   end

   always_comb begin
      crc_base = take ? cfb_pkg::CRC_INIT : crc_ff;
      byte_sel = take ? dev_addr : shift_ff[cfb_pkg::SHIFT_W-1 -: cfb_pkg::BYTE_W];
      crc_step = cfb_pkg::crc_add_byte(crc_base, byte_sel);
   end

   always_comb begin
      busy_in = busy_ff;
      crc_lo_in = crc_lo_ff;
      left_in = left_ff;
      shift_in = shift_ff;
      crc_in = crc_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_byte_in = rsp_byte_ff;
      rsp_last_in = rsp_last_ff;
      if (out_adv) begin
         rsp_valid_in = 1'b0;
         rsp_last_in = 1'b0;
         if (take) begin
            // address beat goes out as the item loads
            busy_in = 1'b1;
            crc_lo_in = 1'b0;
            left_in = pend_item.n_bytes + 3'd1;
            shift_in = load_shift;
            crc_in = crc_step;
            rsp_valid_in = 1'b1;
            rsp_byte_in = dev_addr;
         end else if (busy_ff) begin
            rsp_valid_in = 1'b1;
            if (left_ff != '0) begin
               rsp_byte_in = byte_sel;
               shift_in = {shift_ff[cfb_pkg::SHIFT_W-cfb_pkg::BYTE_W-1:0], 8'h00};
               left_in = left_ff - 3'd1;
               crc_in = crc_step;
            end else if (!crc_lo_ff) begin
               rsp_byte_in = crc_ff[15:8];
               crc_lo_in = 1'b1;
            end else begin
               rsp_byte_in = crc_ff[7:0];
               rsp_last_in = 1'b1;
               busy_in = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         crc_lo_ff <= 1'b0;
         left_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         crc_lo_ff <= crc_lo_in;
         left_ff <= left_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
      crc_ff <= crc_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.frame_byte = rsp_byte_ff;
   assign rsp.last = rsp_last_ff;

endmodule

`default_nettype wire

@@ hdl/cfb_checker.sv @@
`default_nettype none

module cfb_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   input wire logic req_ready,
   input wire logic rsp_valid,
   input wire logic rsp_ready,
   input wire logic [7:0] rsp_frame_byte,
   input wire logic rsp_last
);

   logic req_fire;
   logic rsp_fire;
   logic [2:0] beat_cnt_ff;
   logic [2:0] beat_cnt_in;
   logic [2:0] open_ff;
   logic [2:0] open_in;

   assign req_fire = req_valid && req_ready;
   assign rsp_fire = rsp_valid && rsp_ready;

   // beats of the frame now going out, and frames taken but not finished
   always_comb begin
      beat_cnt_in = beat_cnt_ff;
      if (rsp_fire) begin
         beat_cnt_in = rsp_last ? 3'd0 : beat_cnt_ff + 3'd1;
      end
      open_in = open_ff + {2'b00, req_fire} - {2'b00, rsp_fire && rsp_last};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         beat_cnt_ff <= '0;
         open_ff <= '0;
      end else begin
         beat_cnt_ff <= beat_cnt_in;
         open_ff <= open_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_frame_byte) && $stable(rsp_last))
      else $error("rsp beat changed while stalled");

   a_frame_max: assert property (@(posedge clock) disable iff (reset)
      rsp_fire && !rsp_last |-> beat_cnt_ff < 3'd7)
      else $error("frame longer than eight bytes");

   a_frame_min: assert property (@(posedge clock) disable iff (reset)
      rsp_fire && rsp_last |-> beat_cnt_ff >= 3'd3)
      else $error("frame shorter than four bytes");

   a_no_orphan: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> open_ff != 3'd0)
      else $error("rsp beat with no request outstanding");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid right after reset");

endmodule

bind command_frame_builder_crc16 cfb_checker u_cfb_checker (
   .clock(clock),
   .reset(reset),
   .req_valid(req_ch.valid),
   .req_ready(req_ch.ready),
   .rsp_valid(rsp_ch.valid),
   .rsp_ready(rsp_ch.ready),
   .rsp_frame_byte(rsp_ch.frame_byte),
   .rsp_last(rsp_ch.last)
);

`default_nettype wire

@@ verif/frame_checker.sv @@
`timescale 1ns / 1ps

module frame_checker (
   input wire logic clock,
   input wire logic reset,
   cfb_req_if req_mon,
   cfb_rsp_if rsp_mon,
   input wire logic csr_wr_en,
   input wire logic [7:0] csr_wr_data,
   output int unsigned mismatches,
   output int unsigned bytes_owed
);

   typedef struct packed {
      logic [cfb_pkg::BYTE_W-1:0] frame_byte;
      logic last;
   } frame_beat_type;

   logic [cfb_pkg::BYTE_W-1:0] dev_addr;
   frame_beat_type bytes_due[$];

   initial begin
      mismatches = 0;
      bytes_owed = 0;
      dev_addr = cfb_pkg::ADDR_RESET;
   end

   task automatic report_mismatch(input string what);
      mismatches++;
      $display("%0t mismatch: %s", $realtime, what);
   endtask

   // bit-serial form: feedback is crc msb xor the incoming data bit
   function automatic logic [cfb_pkg::CRC_W-1:0] crc_xmodem_byte(
         input logic [cfb_pkg::CRC_W-1:0] acc,
         input logic [cfb_pkg::BYTE_W-1:0] b);
      logic [cfb_pkg::CRC_W-1:0] r;
      logic fb;
      r = acc;
      for (int k = cfb_pkg::BYTE_W - 1; k >= 0; k--) begin
         fb = r[cfb_pkg::CRC_W-1] ^ b[k];
         r = {r[cfb_pkg::CRC_W-2:0], 1'b0};
         if (fb) begin
            r = r ^ cfb_pkg::CRC_POLY;
         end
      end
      return r;
   endfunction

   task automatic queue_frame(input logic [cfb_pkg::BYTE_W-1:0] cmd,
                              input logic [cfb_pkg::COUNT_W-1:0] n_raw,
                              input logic [cfb_pkg::PAYLOAD_W-1:0] pl);
      logic [cfb_pkg::BYTE_W-1:0] body[$];
      logic [cfb_pkg::COUNT_W-1:0] n;
      logic [cfb_pkg::CRC_W-1:0] crc;
      frame_beat_type beat;
      n = (n_raw > cfb_pkg::MAX_PAYLOAD) ? cfb_pkg::MAX_PAYLOAD : n_raw;
      body.push_back(dev_addr);
      body.push_back(cmd);
      for (int i = n; i > 0; i--) begin
         body.push_back(pl[8*(i-1) +: 8]);
      end
      crc = cfb_pkg::CRC_INIT;
      foreach (body[i]) begin
         crc = crc_xmodem_byte(crc, body[i]);
      end
      body.push_back(crc[15:8]);
      body.push_back(crc[7:0]);
      foreach (body[i]) begin
         beat.frame_byte = body[i];
         beat.last = (i == body.size() - 1);
         bytes_due.push_back(beat);
      end
   endtask

   always @(posedge clock) begin
      frame_beat_type want;
      if (reset) begin
         dev_addr = cfb_pkg::ADDR_RESET;
         bytes_due.delete();
      end else begin
         if (req_mon.valid && req_mon.ready) begin
            queue_frame(req_mon.command, req_mon.payload_bytes, req_mon.payload);
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (bytes_due.size() == 0) begin
               report_mismatch($sformatf("unexpected beat byte %02h last %0b",
                                         rsp_mon.frame_byte, rsp_mon.last));
            end else begin
               want = bytes_due.pop_front();
               if (rsp_mon.frame_byte !== want.frame_byte) begin
                  report_mismatch($sformatf("frame_byte %02h, want %02h",
                                            rsp_mon.frame_byte, want.frame_byte));
               end
               if (rsp_mon.last !== want.last) begin
                  report_mismatch($sformatf("last %0b, want %0b on byte %02h",
                                            rsp_mon.last, want.last, want.frame_byte));
               end
            end
         end
         // address change applies to requests taken after this edge
         if (csr_wr_en) begin
            dev_addr = csr_wr_data;
         end
      end
      bytes_owed <= bytes_due.size();
   end

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 1ps

module testbench;

   localparam int unsigned RANDOM_PHASES = 4;
   localparam int unsigned ITEMS_PER_PHASE = 38;
   localparam int unsigned SETTLE_CYCLES = 20;

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic [7:0] csr_wr_data;
   bit sender_idles;
   bit receiver_stalls;
   int unsigned mismatches;
   int unsigned bytes_owed;

   cfb_req_if req_ch();
   cfb_rsp_if rsp_ch();

   command_frame_builder_crc16 uut (
      .clock(clock),
      .reset(reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   frame_checker frame_check (
      .clock(clock),
      .reset(reset),
      .req_mon(req_ch),
      .rsp_mon(rsp_ch),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .mismatches(mismatches),
      .bytes_owed(bytes_owed)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   initial begin
      #5_000_000;
      $display("command_frame_builder_crc16 regression: fail");
      $finish;
   end

   // mostly short gaps, now and then a long one
   function automatic int unsigned pick_idle(input bit enabled);
      int unsigned r;
      r = $urandom_range(0, 99);
      if (!enabled || r < 45) begin
         return 0;
      end else if (r < 88) begin
         return $urandom_range(1, 3);
      end else begin
         return $urandom_range(6, 24);
      end
   endfunction

   initial begin
      int unsigned hold;
      int unsigned stall;
      rsp_ch.ready = 1'b0;
      @(posedge clock);
      forever begin
         rsp_ch.ready <= 1'b1;
         hold = $urandom_range(1, 12);
         repeat (hold) @(posedge clock);
         stall = pick_idle(receiver_stalls);
         if (stall != 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
      end
   end

   task automatic send_request(input logic [7:0] cmd, input logic [2:0] n,
                               input logic [31:0] pl);
      int unsigned gap;
      gap = pick_idle(sender_idles);
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         req_ch.command <= 8'($urandom);
         req_ch.payload_bytes <= 3'($urandom);
         req_ch.payload <= $urandom;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.command <= cmd;
      req_ch.payload_bytes <= n;
      req_ch.payload <= pl;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   // hold off new requests until every owed byte has come out
   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (bytes_owed != 0) @(posedge clock);
   endtask

   task automatic set_address(input logic [7:0] addr);
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= addr;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic send_random_request();
      logic [7:0] cmd;
      logic [2:0] n;
      logic [31:0] pl;
      int unsigned pick;
      pick = $urandom_range(0, 99);
      cmd = (pick < 5) ? 8'h00 : (pick < 10) ? 8'hff : 8'($urandom);
      // most requests well formed, some with an oversize length
      n = ($urandom_range(0, 99) < 85) ? 3'($urandom_range(0, 4)) : 3'($urandom_range(5, 7));
      pick = $urandom_range(0, 99);
      pl = (pick < 5) ? 32'h0 : (pick < 10) ? 32'hffff_ffff : $urandom;
      send_request(cmd, n, pl);
   endtask

   initial begin
      logic [7:0] phase_addr;
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_wr_data = 8'h00;
      req_ch.valid = 1'b0;
      req_ch.command = 8'h00;
      req_ch.payload_bytes = 3'd0;
      req_ch.payload = 32'h0;
      sender_idles = 1'b1;
      receiver_stalls = 1'b1;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part runs with the reset address
      send_request(8'h00, 3'd0, 32'h0000_0000);
      send_request(8'hff, 3'd0, 32'hffff_ffff);
      for (int k = 1; k <= 4; k++) begin
         send_request(8'h5a, 3'(k), 32'hffff_ffff);
         send_request(8'ha5, 3'(k), 32'h0000_0000);
      end
      // lengths five to seven are cut to four
      send_request(8'h21, 3'd5, 32'h1234_5678);
      send_request(8'h22, 3'd6, 32'h1234_5678);
      send_request(8'h23, 3'd7, 32'h8765_4321);
      send_request(8'h80, 3'd4, 32'h8000_0000);
      send_request(8'h01, 3'd1, 32'h0000_00ff);
      send_request(8'hff, 3'd4, 32'hffff_ffff);
      send_request(8'h00, 3'd4, 32'h0000_0001);
      send_request(8'h7f, 3'd2, 32'hdead_0102);
      send_request(8'h3c, 3'd3, 32'h00ab_cdef);

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         phase_addr = (p == 0) ? 8'h00 : (p == 1) ? 8'hff : 8'($urandom);
         set_address(phase_addr);
         sender_idles = (p != 2);
         receiver_stalls = (p != 2);
         for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
            if (p == 3 && i == ITEMS_PER_PHASE / 2) begin
               wait_drained();
            end
            send_random_request();
         end
      end

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("command_frame_builder_crc16 regression: pass");
      end else begin
         $display("command_frame_builder_crc16 regression: fail");
      end
      $finish;
   end

endmodule
